>>> design/kbr_pkg.sv
// package for the keyboard report builder
// shared constants, item and report types, keymap address function
// no dependencies
package kbr_pkg;

  localparam int MAP_COLS   = 5;
  localparam int MAP_ROWS   = 6;
  localparam int KEY_SLOTS  = 5;
  localparam int MAP_DEPTH  = 4 * MAP_COLS * MAP_ROWS;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam logic [7:0] MOD_BASE   = 8'd232;
  localparam logic [7:0] LAYER_CODE = 8'd240;

  typedef enum logic [1:0] {
    OP_PRESS = 2'd0,
    OP_TICK  = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  // item as it moves from the input register to the apply stage
  typedef struct packed {
    logic vld;
    op_t  op;
    logic ok;
  } stage_item_t;

  typedef struct packed {
    logic [KEY_SLOTS-1:0][7:0] keys;
    logic [7:0]                modifiers;
  } report_t;

  typedef struct packed {
    logic    vld;
    report_t rpt;
  } emit_t;

  function automatic logic [MAP_AW-1:0] map_addr(input logic       side,
                                                 input logic       layer,
                                                 input logic [2:0] col,
                                                 input logic [2:0] row);
    logic [MAP_AW-1:0] plane;
    logic [MAP_AW-1:0] line;
    plane = MAP_AW'({side, layer});
    line  = MAP_AW'(plane * MAP_AW'(MAP_COLS)) + MAP_AW'(col);
    return MAP_AW'(line * MAP_AW'(MAP_ROWS)) + MAP_AW'(row);
  endfunction

endpackage

>>> design/keypress_to_hid_report_builder_top.sv
// top level of the keyboard report builder
// depends on kbr_pkg, kbr_ram, kbr_report_core, kbr_out_buf
//
// usage:
//   in channel: one transaction per item; in_tuser carries the op (key press,
//   report tick, keymap load), in_tdata the key position and load payload.
//   loads write one keymap byte; presses look up the code at the current
//   layer and update the pending report; ticks emit the pending report.
//   out channel: a tick with a nonempty pending report gives two
//   transactions, the report itself (out_tlast low) and then an all-zero
//   release report (out_tlast high). presses, loads and empty ticks give none.
//   path: a tick passes the input register and the apply stage; its report
//   is then registered in the output register. throughput: one item per cycle
//   unless stalled; a reporting tick holds the output register until its release.
//   both keymap layers are read at once so a layer toggle never stalls.
//   reset: rst_n low clears the pipeline, the layer, modifiers and key slots;
//   the keymap is not cleared and must be loaded before keys are pressed.
//   stall: while a reporting tick needs the output register and it is busy (out_tready
//   low, or a release still queued), the whole pipeline holds and in_tready drops.
module keypress_to_hid_report_builder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // side, col_index[2:0], row_index[2:0], load_layer,
                                  // load_code[7:0]
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // modifiers, key_a, key_b, key_c, key_d, key_e
  output logic        out_tlast
);
  import kbr_pkg::*;

  // input register
  logic       s1_valid_r;
  op_t        s1_op_r;
  logic       s1_side_r;
  logic [2:0] s1_col_r;
  logic [2:0] s1_row_r;
  logic       s1_layer_r;
  logic [7:0] s1_code_r;

  logic        adv;
  logic        stall;
  logic        space;
  logic        s1_ok;
  stage_item_t s1_item;
  emit_t       emit;
  report_t     out_rpt;
  logic [7:0]  code_l0;
  logic [7:0]  code_l1;
  logic        map_we;

  assign adv       = !stall;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (adv && in_tvalid) begin
      s1_op_r    <= op_t'(in_tuser);
      s1_side_r  <= in_tdata[0];
      s1_col_r   <= in_tdata[3:1];
      s1_row_r   <= in_tdata[6:4];
      s1_layer_r <= in_tdata[7];
      s1_code_r  <= in_tdata[15:8];
    end
  end

  // out of range positions are ignored for both press and load
  assign s1_ok = (int'(s1_col_r) < MAP_COLS) && (int'(s1_row_r) < MAP_ROWS);

  assign s1_item = '{vld: s1_valid_r, op: s1_op_r, ok: s1_ok};
  assign map_we  = adv && s1_valid_r && (s1_op_r == OP_LOAD) && s1_ok;

  kbr_ram #(
    .WIDTH (8),
    .DEPTH (MAP_DEPTH)
  ) u_keymap (
    .clk     (clk),
    .we      (map_we),
    .waddr   (map_addr(s1_side_r, s1_layer_r, s1_col_r, s1_row_r)),
    .wdata   (s1_code_r),
    .rd_en   (adv),
    .raddr_a (map_addr(s1_side_r, 1'b0, s1_col_r, s1_row_r)),
    .raddr_b (map_addr(s1_side_r, 1'b1, s1_col_r, s1_row_r)),
    .rdata_a (code_l0),
    .rdata_b (code_l1)
  );

  kbr_report_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_item (s1_item),
    .code_l0 (code_l0),
    .code_l1 (code_l1),
    .space   (space),
    .stall   (stall),
    .emit    (emit)
  );

  kbr_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_rpt    (out_rpt),
    .out_last   (out_tlast)
  );

  // modifiers in the low byte, then key slots one to five
  assign out_tdata = {out_rpt.keys, out_rpt.modifiers};

endmodule

>>> design/kbr_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
module kbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> design/kbr_report_core.sv
// apply stage: layer select, modifier and key slot update, tick handling
// depends on kbr_pkg
module kbr_report_core (
  input  logic                clk,
  input  logic                rst_n,
  input  kbr_pkg::stage_item_t s1_item,
  input  logic [7:0]          code_l0,
  input  logic [7:0]          code_l1,
  input  logic                space,
  output logic                stall,
  output kbr_pkg::emit_t      emit
);
  import kbr_pkg::*;

  stage_item_t s2_item_r;
  logic        layer_r, layer_nxt;
  logic [7:0]  mods_r, mods_nxt;
  logic [KEY_SLOTS-1:0][7:0] slots_r, slots_nxt;

  logic       adv;
  logic       nonempty;
  logic [7:0] code;
  logic       dup;
  logic       placed;

  assign code     = layer_r ? code_l1 : code_l0;
  assign nonempty = (slots_r[0] != 8'd0) || (mods_r != 8'd0);
  assign stall    = s2_item_r.vld && (s2_item_r.op == OP_TICK) && nonempty && !space;
  assign adv      = !stall;

  assign emit.vld = adv && s2_item_r.vld && (s2_item_r.op == OP_TICK) && nonempty;
  assign emit.rpt = '{keys: slots_r, modifiers: mods_r};

  always_comb begin
    layer_nxt = layer_r;
    mods_nxt  = mods_r;
    slots_nxt = slots_r;
    dup       = 1'b0;
    placed    = 1'b0;
    if (s2_item_r.vld) begin
      unique case (s2_item_r.op)
        OP_PRESS: begin
          if (s2_item_r.ok) begin
            if (code >= MOD_BASE && code < LAYER_CODE) begin
              mods_nxt = mods_r | (8'd1 << code[2:0]);
            end else if (code == LAYER_CODE) begin
              layer_nxt = !layer_r;
            end else if (code != 8'd0 && code < LAYER_CODE) begin
              for (int i = 0; i < KEY_SLOTS; i++) begin
                if (slots_r[i] == code) begin
                  dup = 1'b1;
                end
              end
              for (int i = 0; i < KEY_SLOTS; i++) begin
                if (!dup && !placed && slots_r[i] == 8'd0) begin
                  slots_nxt[i] = code;
                  placed       = 1'b1;
                end
              end
            end
          end
        end
        OP_TICK: begin
          if (nonempty) begin
            mods_nxt  = 8'd0;
            slots_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_item_r <= '0;
      layer_r   <= 1'b0;
      mods_r    <= 8'd0;
      slots_r   <= '0;
    end else if (adv) begin
      s2_item_r <= s1_item;
      layer_r   <= layer_nxt;
      mods_r    <= mods_nxt;
      slots_r   <= slots_nxt;
    end
  end

endmodule

>>> design/kbr_out_buf.sv
// output register holding a report and a queued empty release report
// depends on kbr_pkg
module kbr_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  kbr_pkg::emit_t emit,
  output logic           space,
  output logic           out_tvalid,
  input  logic           out_tready,
  output kbr_pkg::report_t out_rpt,
  output logic           out_last
);
  import kbr_pkg::*;

  logic    out_valid_r;
  logic    rel_pend_r;
  report_t rpt_r;
  logic    last_r;

  assign space = !out_valid_r || (out_tready && !rel_pend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rel_pend_r  <= 1'b0;
    end else if (emit.vld) begin
      out_valid_r <= 1'b1;
      rel_pend_r  <= 1'b1;
    end else if (out_valid_r && out_tready) begin
      out_valid_r <= rel_pend_r;
      rel_pend_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      rpt_r  <= emit.rpt;
      last_r <= 1'b0;
    end else if (out_valid_r && out_tready && rel_pend_r) begin
      rpt_r  <= '0;
      last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_rpt    = rpt_r;
  assign out_last   = last_r;

endmodule

>>> tb/keypress_to_hid_report_builder_top_tb.sv
// self-checking testbench for keypress_to_hid_report_builder_top
// needs kbr_pkg and the design files only
// a built-in keyboard predictor supplies the expected reports
`timescale 1ns / 100ps

module keypress_to_hid_report_builder_top_tb;
  import kbr_pkg::*;

  // op value the block has no use for, it must be swallowed without a report
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned HOLD_LEN = 400;   // long receiver hold-off for the pressure phase
  localparam int unsigned IDLE_LIMIT = 3000; // cycles without any transaction before giving up
  localparam int unsigned TAIL_CYCLES = 20;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // one input transaction, fields as they travel on in_tdata / in_tuser
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] code;
    logic       layer;
    logic [2:0] row;
    logic [2:0] col;
    logic       side;
  } key_item_t;

  // one output transaction; bit layout equals {out_tlast, out_tdata}
  typedef struct packed {
    logic       last;
    logic [7:0] key_e;
    logic [7:0] key_d;
    logic [7:0] key_c;
    logic [7:0] key_b;
    logic [7:0] key_a;
    logic [7:0] modifiers;
  } hid_rpt_t;

  // everything the keyboard remembers between items
  typedef struct packed {
    logic [MAP_DEPTH-1:0][7:0] keymap;
    logic [MAP_DEPTH-1:0]      loaded;   // entries written so far
    logic                      layer;
    logic [7:0]                mods;
    logic [KEY_SLOTS-1:0][7:0] slots;
  } board_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // side, col_index[2:0], row_index[2:0], load_layer, load_code[7:0]
  logic [1:0]  in_tuser = '0;   // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // modifiers, key_a, key_b, key_c, key_d, key_e
  logic        out_tlast;

  key_item_t   item_backlog[$];  // items waiting to be offered
  hid_rpt_t    due_reports[$];   // reports the block still owes us
  board_t      plan_board;       // shadow used while planning stimulus
  board_t      chk_board;        // shadow advanced on accepted transactions
  idle_mode_t  idle_mode = IDLE_NONE;
  int unsigned hold_asked = 0;
  int unsigned planned_items = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  keypress_to_hid_report_builder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned keymap_pos(input logic side, input logic layer,
                                             input logic [2:0] col, input logic [2:0] row);
    return ((int'(side) * 2 + int'(layer)) * MAP_COLS + int'(col)) * MAP_ROWS + int'(row);
  endfunction

  function automatic board_t board_cleared();
    board_t b;
    b = '0;
    return b;
  endfunction

  // advance the keyboard by one item; a reporting tick yields the report and its release
  function automatic void board_step(inout board_t b, input key_item_t it,
                                     output hid_rpt_t rpt, output hid_rpt_t release_rpt,
                                     output bit reported);
    logic [7:0]  code;
    logic        held;
    logic        on_map;
    int unsigned pos;
    rpt         = '0;
    release_rpt = '0;
    reported    = 1'b0;
    on_map      = int'(it.col) < MAP_COLS && int'(it.row) < MAP_ROWS;
    case (it.op)
      OP_PRESS: begin
        if (on_map) begin
          code = b.keymap[keymap_pos(it.side, b.layer, it.col, it.row)];
          if (code >= MOD_BASE && code < LAYER_CODE) begin
            b.mods[code - MOD_BASE] = 1'b1;
          end else if (code == LAYER_CODE) begin
            b.layer = ~b.layer;
          end else if (code != 8'd0 && code < LAYER_CODE) begin
            // already held keys are not repeated, a full report drops the key
            held = 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
              if (b.slots[i] == code) held = 1'b1;
            for (int i = 0; i < KEY_SLOTS; i++)
              if (!held && b.slots[i] == 8'd0) begin
                b.slots[i] = code;
                held = 1'b1;
              end
          end
        end
      end
      OP_LOAD: begin
        if (on_map) begin
          pos = keymap_pos(it.side, it.layer, it.col, it.row);
          b.keymap[pos] = it.code;
          b.loaded[pos] = 1'b1;
        end
      end
      OP_TICK: begin
        // only a report with slot one or a modifier set goes out
        if (b.slots[0] != 8'd0 || b.mods != 8'd0) begin
          rpt.modifiers = b.mods;
          rpt.key_a = b.slots[0];
          rpt.key_b = b.slots[1];
          rpt.key_c = b.slots[2];
          rpt.key_d = b.slots[3];
          rpt.key_e = b.slots[4];
          b.mods  = '0;
          b.slots = '0;
          release_rpt.last = 1'b1;
          reported = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver

  // presents backlog items on the in channel, predicts on every accepted transaction
  key_item_t offered;
  always @(posedge clk) begin
    hid_rpt_t rpt;
    hid_rpt_t release_rpt;
    bit       reported;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        board_step(chk_board, offered, rpt, release_rpt, reported);
        if (reported) begin
          due_reports.push_back(rpt);
          due_reports.push_back(release_rpt);
        end
      end
      // free to change what is offered only once the last offer was taken
      if (!in_tvalid || in_tready) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= ((idle_mode == IDLE_SEND) ? 74 :
                                         (idle_mode == IDLE_BOTH) ? 9 : 0)) begin
          offered = item_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {offered.code, offered.layer, offered.row, offered.col, offered.side};
          in_tuser  <= offered.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // checks every out transaction and drives out_tready, including the long hold-off
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    hid_rpt_t got;
    hid_rpt_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = hid_rpt_t'({out_tlast, out_tdata});
        if (due_reports.size() == 0) begin
          $error("unexpected report: tlast %0b tdata %0h", out_tlast, out_tdata);
          fail_count++;
        end else begin
          want = due_reports.pop_front();
          check_field("modifiers", want.modifiers, got.modifiers);
          check_field("key_a", want.key_a, got.key_a);
          check_field("key_b", want.key_b, got.key_b);
          check_field("key_c", want.key_c, got.key_c);
          check_field("key_d", want.key_d, got.key_d);
          check_field("key_e", want.key_e, got.key_e);
          check_field("last", 8'(want.last), 8'(got.last));
        end
      end
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left   = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= $urandom_range(99) >= ((idle_mode == IDLE_RECV) ? 74 :
                                            (idle_mode == IDLE_BOTH) ? 9 : 0);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  // a run that stops moving transactions for too long counts as hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[keypress_to_hid_report_builder_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // queue one item and keep the planning shadow in step so presses only hit loaded entries
  task automatic plan_item(input logic [1:0] op, input logic side, input logic [2:0] col,
                           input logic [2:0] row, input logic layer, input logic [7:0] code);
    key_item_t it;
    hid_rpt_t  rpt;
    hid_rpt_t  release_rpt;
    bit        reported;
    it = '{op: op, code: code, layer: layer, row: row, col: col, side: side};
    board_step(plan_board, it, rpt, release_rpt, reported);
    item_backlog.push_back(it);
    if (op != OP_UNUSED) planned_items++;
  endtask

  // mostly ordinary keys, with modifiers, layer toggles and dead codes mixed in
  function automatic logic [7:0] random_code();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return 8'($urandom_range(231, 1));
    if (pick < 75) return 8'($urandom_range(239, 232));
    if (pick < 83) return LAYER_CODE;
    if (pick < 90) return 8'd0;
    return 8'($urandom_range(255, 241));
  endfunction

  // press a loaded key at the current layer, or load one if none turns up
  task automatic plan_random_press();
    logic       s;
    logic [2:0] c;
    logic [2:0] r;
    bit         found;
    found = 1'b0;
    s = 1'b0;
    c = '0;
    r = '0;
    for (int t = 0; t < 16 && !found; t++) begin
      s = 1'($urandom_range(1));
      c = 3'($urandom_range(MAP_COLS - 1));
      r = 3'($urandom_range(MAP_ROWS - 1));
      found = plan_board.loaded[keymap_pos(s, plan_board.layer, c, r)];
    end
    if (found)
      plan_item(OP_PRESS, s, c, r, 1'($urandom_range(1)), 8'($urandom));
    else
      plan_item(OP_LOAD, s, c, r, plan_board.layer, random_code());
  endtask

  // off-map positions, the unused op and stray ticks
  task automatic plan_noise();
    logic [2:0] c;
    logic [2:0] r;
    c = 3'($urandom_range(7));
    r = 3'($urandom_range(7));
    if ($urandom_range(1) == 0) c = 3'($urandom_range(7, MAP_COLS));
    else r = 3'($urandom_range(7, MAP_ROWS));
    case ($urandom_range(3))
      0: plan_item(OP_PRESS, 1'($urandom_range(1)), c, r, 1'($urandom_range(1)), 8'($urandom));
      1: plan_item(OP_LOAD, 1'($urandom_range(1)), c, r, 1'($urandom_range(1)), 8'($urandom));
      2: plan_item(OP_UNUSED, 1'($urandom_range(1)), 3'($urandom), 3'($urandom),
                   1'($urandom_range(1)), 8'($urandom));
      default: plan_item(OP_TICK, 1'($urandom_range(1)), 3'($urandom), 3'($urandom),
                         1'($urandom_range(1)), 8'($urandom));
    endcase
  endtask

  // a burst is a few keymap loads, a run of presses and the tick that reports them
  task automatic plan_burst(input int unsigned max_presses);
    int unsigned loads;
    loads = ($countones(plan_board.loaded) < MAP_DEPTH / 2) ? $urandom_range(6, 2)
                                                            : $urandom_range(2);
    repeat (loads)
      plan_item(OP_LOAD, 1'($urandom_range(1)), 3'($urandom_range(MAP_COLS - 1)),
                3'($urandom_range(MAP_ROWS - 1)), 1'($urandom_range(1)), random_code());
    repeat ($urandom_range(max_presses, 1)) plan_random_press();
    if ($urandom_range(99) < 15) plan_noise();
    plan_item(OP_TICK, 1'($urandom_range(1)), 3'($urandom), 3'($urandom),
              1'($urandom_range(1)), 8'($urandom));
  endtask

  task automatic drain();
    while (item_backlog.size() != 0 || in_tvalid || due_reports.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input idle_mode_t mode, input int unsigned n_items,
                           input bit with_hold);
    int unsigned start;
    idle_mode = mode;
    start = planned_items;
    if (with_hold) begin
      // short bursts, most ticks reporting, so the output side backs up
      hold_asked++;
      repeat (40) plan_burst(2);
    end
    while (planned_items - start < n_items) plan_burst(8);
    drain();
  endtask

  initial begin
    plan_board = board_cleared();
    chk_board  = board_cleared();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: map a handful of keys on both halves and layers
    plan_item(OP_LOAD, 1'b0, 3'd0, 3'd0, 1'b0, 8'd4);
    plan_item(OP_LOAD, 1'b1, 3'd4, 3'd5, 1'b0, 8'd231);
    plan_item(OP_LOAD, 1'b0, 3'd1, 3'd0, 1'b0, MOD_BASE);
    plan_item(OP_LOAD, 1'b1, 3'd1, 3'd1, 1'b0, 8'd239);
    plan_item(OP_LOAD, 1'b0, 3'd2, 3'd2, 1'b0, LAYER_CODE);
    plan_item(OP_LOAD, 1'b0, 3'd2, 3'd2, 1'b1, LAYER_CODE);
    plan_item(OP_LOAD, 1'b0, 3'd0, 3'd0, 1'b1, 8'd5);
    plan_item(OP_LOAD, 1'b1, 3'd3, 3'd3, 1'b1, 8'd255);
    plan_item(OP_LOAD, 1'b0, 3'd3, 3'd3, 1'b0, 8'd0);
    plan_item(OP_LOAD, 1'b1, 3'd7, 3'd7, 1'b1, 8'hAA);       // off the map, dropped
    plan_item(OP_TICK, 1'b0, 3'd0, 3'd0, 1'b0, 8'd0);        // nothing pending, no report
    // ordinary key, its repeat, the top ordinary code, lowest and highest modifier
    plan_item(OP_PRESS, 1'b0, 3'd0, 3'd0, 1'b0, 8'd0);
    plan_item(OP_PRESS, 1'b0, 3'd0, 3'd0, 1'b1, 8'hFF);
    plan_item(OP_PRESS, 1'b1, 3'd4, 3'd5, 1'b0, 8'd0);
    plan_item(OP_PRESS, 1'b0, 3'd1, 3'd0, 1'b0, 8'd0);
    plan_item(OP_PRESS, 1'b1, 3'd1, 3'd1, 1'b0, 8'd0);
    plan_item(OP_PRESS, 1'b0, 3'd3, 3'd3, 1'b0, 8'd0);       // zero code, no effect
    plan_item(OP_PRESS, 1'b1, 3'd7, 3'd7, 1'b1, 8'hFF);      // off the map, no effect
    plan_item(OP_UNUSED, 1'b1, 3'd7, 3'd7, 1'b1, 8'hFF);
    plan_item(OP_TICK, 1'b1, 3'd7, 3'd7, 1'b1, 8'hFF);
    // layer toggle, key on the special layer, dead high code, toggle back
    plan_item(OP_PRESS, 1'b0, 3'd2, 3'd2, 1'b0, 8'd0);
    plan_item(OP_PRESS, 1'b0, 3'd0, 3'd0, 1'b0, 8'd0);
    plan_item(OP_PRESS, 1'b1, 3'd3, 3'd3, 1'b0, 8'd0);
    plan_item(OP_PRESS, 1'b0, 3'd2, 3'd2, 1'b0, 8'd0);
    plan_item(OP_TICK, 1'b0, 3'd0, 3'd0, 1'b0, 8'd0);
    drain();

    // random bursts under each flow-control pattern, pressure first
    run_phase(IDLE_NONE, 300, 1'b1);
    run_phase(IDLE_SEND, 260, 1'b0);
    run_phase(IDLE_RECV, 260, 1'b0);
    run_phase(IDLE_BOTH, 260, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_reports.size() == 0)
      $display("[keypress_to_hid_report_builder_top] OK");
    else
      $display("[keypress_to_hid_report_builder_top] ERROR");
    $finish;
  end

endmodule

>>> keypress_to_hid_report_builder_top.f
design/kbr_pkg.sv
design/kbr_ram.sv
design/kbr_report_core.sv
design/kbr_out_buf.sv
design/keypress_to_hid_report_builder_top.sv
tb/keypress_to_hid_report_builder_top_tb.sv
